// File: rtl/daisy_chain_readback_crc15_checker_core_defines.svh
// Assertion macros for the daisy-chain readback checker.
// Included by the checker module; needs nothing else.
`ifndef DAISY_CHAIN_READBACK_CRC15_CHECKER_CORE_DEFINES_SVH
`define DAISY_CHAIN_READBACK_CRC15_CHECKER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define DCRC_ASSERT_NOW(label, clk, off, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (off) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define DCRC_ASSERT_NEXT(label, clk, off, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (off) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/dcrc_pkg.sv
// Shared types, register codes and the byte-wide CRC-15 step for the
// daisy-chain readback checker. No dependencies.
`default_nettype none
package dcrc_pkg;

   localparam int MAX_DEVICES = 16;
   localparam int DEV_LIMIT   = (MAX_DEVICES < 16) ? MAX_DEVICES : 16;
   localparam logic [4:0] DEV_CAP = 5'(DEV_LIMIT);

   localparam logic [15:0] CRC_SEED    = 16'd16;
   localparam logic [2:0]  POS_CHECK_HI = 3'd6;
   localparam logic [2:0]  POS_CHECK_LO = 3'd7;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE_COUNT   = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CRC_POLYNOMIAL = 4'd1;

   localparam logic [4:0]  DEVICE_COUNT_RESET   = 5'd1;
   localparam logic [14:0] CRC_POLYNOMIAL_RESET = 15'h4599;

   typedef struct packed {
      logic [4:0]  device_count;
      logic [14:0] crc_polynomial;
   } cfg_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_start;
      logic [2:0] register_group;
   } req_item_type;

   typedef struct packed {
      logic [3:0]  device_index;
      logic [3:0]  first_cell_index;
      logic [15:0] code_a;
      logic [15:0] code_b;
      logic [15:0] code_c;
      logic        check_ok;
      logic        frame_error;
      logic        last_device;
   } rsp_item_type;

   // Advance the remainder by one byte; the table entry is built bit by bit.
   function automatic logic [15:0] crc_step(input logic [15:0] rem,
                                            input logic [7:0]  data,
                                            input logic [14:0] poly);
      logic [7:0]  addr;
      logic [15:0] r;
      addr = rem[14:7] ^ data;
      r    = {1'b0, addr, 7'b0};
      for (int k = 0; k < 8; k++) begin
         if (r[14]) begin
            r = {r[14:0], 1'b0} ^ {1'b0, poly};
         end else begin
            r = {r[14:0], 1'b0};
         end
      end
      return {rem[7:0], 8'h00} ^ r;
   endfunction

   // Groups per frame: zero counts as one, large values are capped.
   function automatic logic [4:0] effective_count(input logic [4:0] count);
      logic [4:0] n;
      n = (count == 5'd0) ? 5'd1 : count;
      if (n > DEV_CAP) begin
         n = DEV_CAP;
      end
      return n;
   endfunction

endpackage
`default_nettype wire

// File: rtl/dcrc_csr.sv
// Configuration registers: device count and CRC polynomial.
// Depends on dcrc_pkg.
`default_nettype none
module dcrc_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [dcrc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [dcrc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output dcrc_pkg::cfg_type                     cfg
);
   import dcrc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DEVICE_COUNT:   cfg_in.device_count   = csr_wdata[4:0];
            CSR_CRC_POLYNOMIAL: cfg_in.crc_polynomial = csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_count   <= DEVICE_COUNT_RESET;
         cfg_ff.crc_polynomial <= CRC_POLYNOMIAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/dcrc_input_stage.sv
// Input register for received bytes; stalls the sender while a byte waits.
// Depends on dcrc_pkg.
`default_nettype none
module dcrc_input_stage (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire dcrc_pkg::req_item_type req_item,
   input  wire logic                   advance,
   output logic                        item_valid,
   output dcrc_pkg::req_item_type      item
);
   import dcrc_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;
   logic         load;

   assign req_stall  = valid_ff && !advance;
   assign load       = req_valid && !req_stall;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in = 1'b1;
         item_in  = req_item;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule
`default_nettype wire

// File: rtl/dcrc_group_engine.sv
// Per-byte group state: CRC remainder, byte and device counters, data bytes,
// sticky error, and the result of each completed group. Depends on dcrc_pkg.
`default_nettype none
module dcrc_group_engine (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire dcrc_pkg::cfg_type      cfg,
   input  wire logic                   item_valid,
   input  wire dcrc_pkg::req_item_type item,
   input  wire logic                   out_ready,
   output logic                        advance,
   output logic                        result_load,
   output dcrc_pkg::rsp_item_type      result
);
   import dcrc_pkg::*;

   logic [15:0] crc_ff, crc_in;
   logic [2:0]  pos_ff, pos_in;
   logic [3:0]  dev_ff, dev_in;
   logic        sticky_ff, sticky_in;
   logic [2:0]  group_ff, group_in;
   logic [7:0]  data_ff [6];
   logic [7:0]  check_hi_ff;

   logic [15:0] crc_base;
   logic [2:0]  pos_cur;
   logic [3:0]  dev_cur;
   logic        sticky_cur;
   logic        group_end;
   logic [15:0] expected;
   logic        ok;
   logic [4:0]  n_dev;
   logic        last;

   // A frame start restarts the group before this byte is taken.
   assign crc_base   = item.frame_start ? CRC_SEED : crc_ff;
   assign pos_cur    = item.frame_start ? 3'd0 : pos_ff;
   assign dev_cur    = item.frame_start ? 4'd0 : dev_ff;
   assign sticky_cur = item.frame_start ? 1'b0 : sticky_ff;
   assign group_in   = item.frame_start ? item.register_group : group_ff;

   assign group_end   = (pos_cur == POS_CHECK_LO);
   assign advance     = item_valid && (!group_end || out_ready);
   assign result_load = advance && group_end;

   assign expected = {crc_ff[14:0], 1'b0};
   assign ok       = (expected == {check_hi_ff, item.rx_byte});
   assign n_dev    = effective_count(cfg.device_count);
   assign last     = ({1'b0, dev_cur} >= (n_dev - 5'd1));

   always_comb begin
      crc_in    = crc_base;
      pos_in    = pos_cur + 3'd1;
      dev_in    = dev_cur;
      sticky_in = sticky_cur;
      if (pos_cur < POS_CHECK_HI) begin
         crc_in = crc_step(crc_base, item.rx_byte, cfg.crc_polynomial);
      end else if (group_end) begin
         crc_in    = CRC_SEED;
         pos_in    = 3'd0;
         sticky_in = sticky_cur | !ok;
         dev_in    = last ? 4'd0 : dev_cur + 4'd1;
      end
   end

   always_comb begin
      result.device_index     = dev_cur;
      result.first_cell_index = {1'b0, group_ff} + {group_ff, 1'b0};
      result.code_a           = {data_ff[1], data_ff[0]};
      result.code_b           = {data_ff[3], data_ff[2]};
      result.code_c           = {data_ff[5], data_ff[4]};
      result.check_ok         = ok;
      result.frame_error      = sticky_cur | !ok;
      result.last_device      = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff    <= CRC_SEED;
         pos_ff    <= 3'd0;
         dev_ff    <= 4'd0;
         sticky_ff <= 1'b0;
         group_ff  <= 3'd0;
      end else if (advance) begin
         crc_ff    <= crc_in;
         pos_ff    <= pos_in;
         dev_ff    <= dev_in;
         sticky_ff <= sticky_in;
         group_ff  <= group_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (pos_cur < POS_CHECK_HI) begin
            data_ff[pos_cur] <= item.rx_byte;
         end
         if (pos_cur == POS_CHECK_HI) begin
            check_hi_ff <= item.rx_byte;
         end
      end
   end

endmodule
`default_nettype wire

// File: rtl/dcrc_output_stage.sv
// Result register; holds a group result until the receiver takes it.
// Depends on dcrc_pkg.
`default_nettype none
module dcrc_output_stage (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   result_load,
   input  wire dcrc_pkg::rsp_item_type result,
   output logic                        out_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output dcrc_pkg::rsp_item_type      rsp_item
);
   import dcrc_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   assign out_ready = !valid_ff || !rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

   always_comb begin
      if (result_load) begin
         valid_in = 1'b1;
      end else if (rsp_stall) begin
         valid_in = valid_ff;
      end else begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_load) begin
         item_ff <= result;
      end
   end

endmodule
`default_nettype wire

// File: rtl/daisy_chain_readback_crc15_checker_core.sv
// Daisy-chain readback checker: takes one received byte per transfer and, on
// the eighth byte of each device group, returns the device index, first cell
// index, three 16-bit codes, the CRC-15 check result, the sticky frame error
// and a last-device mark. It accepts one byte every cycle except while a
// stalled result holds back the byte that would complete the next group;
// that byte and all bytes behind it wait, earlier bytes keep flowing. A
// result passes the input register, then the byte-wide CRC step and group
// logic in the engine, then the result register. Write configuration only
// while no bytes are in flight.
// Depends on dcrc_pkg, dcrc_csr, dcrc_input_stage, dcrc_group_engine and
// dcrc_output_stage.
`default_nettype none
module daisy_chain_readback_crc15_checker_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [7:0]                       req_rx_byte,
   input  wire logic                             req_frame_start,
   input  wire logic [2:0]                       req_register_group,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [3:0]                            rsp_device_index,
   output logic [3:0]                            rsp_first_cell_index,
   output logic [15:0]                           rsp_code_a,
   output logic [15:0]                           rsp_code_b,
   output logic [15:0]                           rsp_code_c,
   output logic                                  rsp_check_ok,
   output logic                                  rsp_frame_error,
   output logic                                  rsp_last_device,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [dcrc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [dcrc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import dcrc_pkg::*;

   cfg_type      cfg;
   req_item_type req_item;
   req_item_type item;
   rsp_item_type result;
   rsp_item_type rsp_item;
   logic         item_valid;
   logic         advance;
   logic         result_load;
   logic         out_ready;

   assign req_item.rx_byte        = req_rx_byte;
   assign req_item.frame_start    = req_frame_start;
   assign req_item.register_group = req_register_group;

   assign rsp_device_index     = rsp_item.device_index;
   assign rsp_first_cell_index = rsp_item.first_cell_index;
   assign rsp_code_a           = rsp_item.code_a;
   assign rsp_code_b           = rsp_item.code_b;
   assign rsp_code_c           = rsp_item.code_c;
   assign rsp_check_ok         = rsp_item.check_ok;
   assign rsp_frame_error      = rsp_item.frame_error;
   assign rsp_last_device      = rsp_item.last_device;

   dcrc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dcrc_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   dcrc_group_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .item_valid  (item_valid),
      .item        (item),
      .out_ready   (out_ready),
      .advance     (advance),
      .result_load (result_load),
      .result      (result)
   );

   dcrc_output_stage u_output (
      .clock       (clock),
      .reset       (reset),
      .result_load (result_load),
      .result      (result),
      .out_ready   (out_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item)
   );

endmodule
`default_nettype wire

// File: rtl/dcrc_checker.sv
// Port-level checks for the readback checker core, attached by bind.
// Depends on dcrc_pkg and the assertion macro header.
`default_nettype none
`include "daisy_chain_readback_crc15_checker_core_defines.svh"
module dcrc_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_stall,
   input wire logic [7:0]                       req_rx_byte,
   input wire logic                             req_frame_start,
   input wire logic [2:0]                       req_register_group,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_stall,
   input wire logic [3:0]                       rsp_device_index,
   input wire logic [3:0]                       rsp_first_cell_index,
   input wire logic [15:0]                      rsp_code_a,
   input wire logic [15:0]                      rsp_code_b,
   input wire logic [15:0]                      rsp_code_c,
   input wire logic                             rsp_check_ok,
   input wire logic                             rsp_frame_error,
   input wire logic                             rsp_last_device,
   input wire logic                             csr_valid,
   input wire logic                             csr_ready,
   input wire logic [dcrc_pkg::CSR_INDEX_W-1:0] csr_index,
   input wire logic [dcrc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import dcrc_pkg::*;

   logic [CSR_INDEX_W-1:0] unused_index;
   logic [CSR_DATA_W-1:0]  unused_wdata;
   logic                   unused_bits;

   assign unused_index = csr_index;
   assign unused_wdata = csr_wdata;
   assign unused_bits  = req_valid ^ req_stall ^ (^req_rx_byte) ^ req_frame_start
                         ^ (^req_register_group) ^ csr_valid ^ csr_ready
                         ^ (^unused_index) ^ (^unused_wdata);

   // Reset drops any pending result.
   `DCRC_ASSERT_NEXT(a_reset_clears_rsp, clock, 1'b0, reset, !rsp_valid, "rsp_valid after reset")

   // A failed check always marks the frame.
   `DCRC_ASSERT_NOW(a_fail_sets_error, clock, reset, rsp_valid && !rsp_check_ok,
                    rsp_frame_error, "check failure without frame_error")

   // Cell index is the group times three, kept to four bits.
   `DCRC_ASSERT_NOW(a_cell_index, clock, reset, rsp_valid,
                    rsp_first_cell_index == 4'd0 || rsp_first_cell_index == 4'd3 || rsp_first_cell_index == 4'd6 || rsp_first_cell_index == 4'd9 || rsp_first_cell_index == 4'd12 || rsp_first_cell_index == 4'd15 || rsp_first_cell_index == 4'd2 || rsp_first_cell_index == 4'd5,
                    "first_cell_index not a group multiple")

   // Hold a stalled result.
   `DCRC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                     rsp_valid && $stable(rsp_device_index) && $stable(rsp_code_a) && $stable(rsp_code_b) && $stable(rsp_code_c) && $stable(rsp_check_ok) && $stable(rsp_frame_error) && $stable(rsp_last_device),
                     "stalled result changed")

endmodule

bind daisy_chain_readback_crc15_checker_core dcrc_checker u_dcrc_checker (.*);
`default_nettype wire
